FILE: rtl/epth_pkg.sv
// Shared types, constants and elaboration-time sine table builder for the
// Euler pose to homogeneous transform pipeline. No dependencies.
package epth_pkg;

  localparam int FracBitsDef = 16;
  localparam int AngW        = 10;
  localparam int PosW        = 20;
  localparam int TransW      = 21;
  localparam int TransMax    = 1048575;
  localparam int TransMin    = -1048576;

  localparam logic [63:0] PiQ31       = 64'd6746518852;
  localparam logic [63:0] DegHalfTurn = 64'd180;
  localparam logic [63:0] HalfQ31     = 64'd1 << 30;
  localparam logic [63:0] OneQ31      = 64'd1 << 31;

  // sine values for 0..90 degrees, up to 30 fraction bits (31 bits wide)
  typedef logic [30:0] sin_tab_t [0:90];

  // table address plus sign for one angle in 0..359
  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } quad_t;

  // payload that rides alongside the angle/matrix pipeline
  typedef struct packed {
    logic                   vld;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic                   rot;
  } side_t;

  function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HalfQ31) >> 31;
  endfunction

  // Taylor series in unsigned Q31, every step rounded half up
  function automatic logic [63:0] sin_q31(input int r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(r) * PiQ31 + 64'd90) / DegHalfTurn;
    x2   = q31_mul(x, x);
    term = x;
    sum  = signed'(x);
    term = (q31_mul(term, x2) + 64'd3) / 64'd6;     sum = sum - signed'(term);
    term = (q31_mul(term, x2) + 64'd10) / 64'd20;   sum = sum + signed'(term);
    term = (q31_mul(term, x2) + 64'd21) / 64'd42;   sum = sum - signed'(term);
    term = (q31_mul(term, x2) + 64'd36) / 64'd72;   sum = sum + signed'(term);
    term = (q31_mul(term, x2) + 64'd55) / 64'd110;  sum = sum - signed'(term);
    term = (q31_mul(term, x2) + 64'd78) / 64'd156;  sum = sum + signed'(term);
    term = (q31_mul(term, x2) + 64'd105) / 64'd210; sum = sum - signed'(term);
    term = (q31_mul(term, x2) + 64'd136) / 64'd272; sum = sum + signed'(term);
    term = (q31_mul(term, x2) + 64'd171) / 64'd342; sum = sum - signed'(term);
    if (sum < 0) sum = 0;
    if (sum > signed'(OneQ31)) sum = signed'(OneQ31);
    return unsigned'(sum);
  endfunction

  function automatic sin_tab_t build_sin_tab(input int frac);
    sin_tab_t    tab;
    logic [63:0] s;
    for (int r = 0; r <= 90; r++) begin
      s      = sin_q31(r);
      tab[r] = 31'((s + (64'd1 << (30 - frac))) >> (31 - frac));
    end
    return tab;
  endfunction

  // fold an angle in 0..359 onto the first quadrant
  function automatic quad_t sin_quad(input logic [8:0] a);
    quad_t q;
    if (a < 9'd90) begin
      q.neg = 1'b0;
      q.idx = 7'(a);
    end else if (a < 9'd180) begin
      q.neg = 1'b0;
      q.idx = 7'(9'd180 - a);
    end else if (a < 9'd270) begin
      q.neg = 1'b1;
      q.idx = 7'(a - 9'd180);
    end else begin
      q.neg = 1'b1;
      q.idx = 7'(9'd360 - a);
    end
    return q;
  endfunction

endpackage

FILE: rtl/epth_angle.sv
// Angle front end: modulo-360 reduction, then sine/cosine table lookup.
// Two register stages. Depends on epth_pkg.
module epth_angle #(
  parameter int FRAC_BITS = epth_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [epth_pkg::AngW-1:0] ang_i [3],
  input  epth_pkg::side_t                 side_i,
  output logic signed [FRAC_BITS+1:0]     sin_o [3],
  output logic signed [FRAC_BITS+1:0]     cos_o [3],
  output epth_pkg::side_t                 side_o
);
  import epth_pkg::*;

  localparam int        MW     = FRAC_BITS + 2;
  localparam sin_tab_t  SinTab = build_sin_tab(FRAC_BITS);

  logic [8:0]           red_d [3];
  logic [8:0]           red_q [3];
  side_t                s1_q;
  logic signed [MW-1:0] sin_d [3];
  logic signed [MW-1:0] cos_d [3];
  logic signed [MW-1:0] sin_q [3];
  logic signed [MW-1:0] cos_q [3];
  side_t                s2_q;

  function automatic logic signed [MW-1:0] lookup(input quad_t q);
    logic signed [MW-1:0] v;
    v = signed'(MW'(SinTab[q.idx][FRAC_BITS:0]));
    return q.neg ? -v : v;
  endfunction

  // stage 1: shift into 208..1231, then at most one subtract of 360/720/1080
  always_comb begin
    logic signed [11:0] wide;
    logic [10:0]        u;
    for (int i = 0; i < 3; i++) begin
      wide = 12'(ang_i[i]) + 12'sd720;
      u    = wide[10:0];
      if (u >= 11'd1080)     red_d[i] = 9'(u - 11'd1080);
      else if (u >= 11'd720) red_d[i] = 9'(u - 11'd720);
      else if (u >= 11'd360) red_d[i] = 9'(u - 11'd360);
      else                   red_d[i] = 9'(u);
    end
  end

  // stage 2: cos(a) = sin(a + 90)
  always_comb begin
    logic [8:0] c;
    for (int i = 0; i < 3; i++) begin
      c        = (red_q[i] >= 9'd270) ? red_q[i] - 9'd270 : red_q[i] + 9'd90;
      sin_d[i] = lookup(sin_quad(red_q[i]));
      cos_d[i] = lookup(sin_quad(c));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= side_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  assign sin_o  = sin_q;
  assign cos_o  = cos_q;
  assign side_o = s2_q;

endmodule

FILE: rtl/epth_rot.sv
// Rotation matrix R = Rz * Ry * Rx from sines and cosines.
// Four register stages: multiply, round, multiply, round/sum/clamp. Depends on epth_pkg.
module epth_rot #(
  parameter int FRAC_BITS = epth_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [FRAC_BITS+1:0] sin_i [3],
  input  logic signed [FRAC_BITS+1:0] cos_i [3],
  input  epth_pkg::side_t             side_i,
  output logic signed [FRAC_BITS+1:0] m_o [9],
  output epth_pkg::side_t             side_o
);
  import epth_pkg::*;

  localparam int MW = FRAC_BITS + 2;
  localparam int SW = MW + 1;
  localparam int PW = 2 * MW;
  localparam logic signed [SW-1:0] One  = SW'(2 ** FRAC_BITS);
  localparam logic [PW:0]          Half = (PW + 1)'(2 ** (FRAC_BITS - 1));

  // product slots of the first multiply stage
  localparam int CzSy = 0, SzSy = 1, CzCy = 2, SzCy = 3, SzCx = 4;
  localparam int CzCx = 5, SzSx = 6, CzSx = 7, CySx = 8, CyCx = 9;

  logic signed [MW-1:0] sx, cx, sy, cy, sz, cz;

  logic signed [PW-1:0] p3_q [10];
  logic signed [MW-1:0] nsy3_q;
  logic signed [MW-1:0] sx3_q, cx3_q;
  side_t                s3_q;

  logic signed [MW-1:0] r4_q [10];
  logic signed [MW-1:0] nsy4_q;
  logic signed [MW-1:0] sx4_q, cx4_q;
  side_t                s4_q;

  logic signed [PW-1:0] p5_q [4];
  logic signed [MW-1:0] r5_q [10];
  logic signed [MW-1:0] nsy5_q;
  side_t                s5_q;

  logic signed [MW-1:0] m_d [9];
  logic signed [MW-1:0] m_q [9];
  side_t                s6_q;

  // half away from zero; magnitudes here never exceed one
  function automatic logic signed [MW-1:0] rnd(input logic signed [PW-1:0] v);
    logic [PW-1:0]        mag;
    logic [PW:0]          r;
    logic signed [MW-1:0] res;
    mag = v[PW-1] ? unsigned'(-v) : unsigned'(v);
    r   = ({1'b0, mag} + Half) >> FRAC_BITS;
    res = signed'(r[MW-1:0]);
    return v[PW-1] ? -res : res;
  endfunction

  function automatic logic signed [MW-1:0] clamp(input logic signed [SW-1:0] v);
    if (v > One)  return MW'(One);
    if (v < -One) return MW'(-One);
    return MW'(v);
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [MW-1:0] a,
                                               input logic signed [MW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  assign sx = sin_i[0];
  assign cx = cos_i[0];
  assign sy = sin_i[1];
  assign cy = cos_i[1];
  assign sz = sin_i[2];
  assign cz = cos_i[2];

  // m[i] = r(a*b) +/- c for the triple-product entries
  always_comb begin
    m_d[0] = clamp(SW'(r5_q[CzCy]));
    m_d[1] = clamp(SW'(rnd(p5_q[0])) - SW'(r5_q[SzCx]));
    m_d[2] = clamp(SW'(rnd(p5_q[1])) + SW'(r5_q[SzSx]));
    m_d[3] = clamp(SW'(r5_q[SzCy]));
    m_d[4] = clamp(SW'(rnd(p5_q[2])) + SW'(r5_q[CzCx]));
    m_d[5] = clamp(SW'(rnd(p5_q[3])) - SW'(r5_q[CzSx]));
    m_d[6] = clamp(SW'(nsy5_q));
    m_d[7] = clamp(SW'(r5_q[CySx]));
    m_d[8] = clamp(SW'(r5_q[CyCx]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
      s4_q <= '0;
      s5_q <= '0;
      s6_q <= '0;
    end else begin
      s3_q <= side_i;
      s4_q <= s3_q;
      s5_q <= s4_q;
      s6_q <= s5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_q[CzSy] <= mul(cz, sy);
    p3_q[SzSy] <= mul(sz, sy);
    p3_q[CzCy] <= mul(cz, cy);
    p3_q[SzCy] <= mul(sz, cy);
    p3_q[SzCx] <= mul(sz, cx);
    p3_q[CzCx] <= mul(cz, cx);
    p3_q[SzSx] <= mul(sz, sx);
    p3_q[CzSx] <= mul(cz, sx);
    p3_q[CySx] <= mul(cy, sx);
    p3_q[CyCx] <= mul(cy, cx);
    nsy3_q     <= -sy;
    sx3_q      <= sx;
    cx3_q      <= cx;

    for (int i = 0; i < 10; i++) r4_q[i] <= rnd(p3_q[i]);
    nsy4_q     <= nsy3_q;
    sx4_q      <= sx3_q;
    cx4_q      <= cx3_q;

    p5_q[0]    <= mul(r4_q[CzSy], sx4_q);
    p5_q[1]    <= mul(r4_q[CzSy], cx4_q);
    p5_q[2]    <= mul(r4_q[SzSy], sx4_q);
    p5_q[3]    <= mul(r4_q[SzSy], cx4_q);
    r5_q       <= r4_q;
    nsy5_q     <= nsy4_q;

    m_q        <= m_d;
  end

  assign m_o    = m_q;
  assign side_o = s6_q;

endmodule

FILE: rtl/epth_xlate.sv
// Translation column: R times offset (or offset as is), rounded and saturated.
// Two register stages, the second is the result register. Depends on epth_pkg.
module epth_xlate #(
  parameter int FRAC_BITS = epth_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [FRAC_BITS+1:0]        m_i [9],
  input  epth_pkg::side_t                    side_i,
  output logic signed [FRAC_BITS+1:0]        m_o [9],
  output logic signed [epth_pkg::TransW-1:0] trans_o [3],
  output logic                               valid_o
);
  import epth_pkg::*;

  localparam int MW = FRAC_BITS + 2;
  localparam int PW = MW + PosW;
  localparam int AW = PW + 2;
  localparam int RW = 23;
  localparam logic [AW:0] Half = (AW + 1)'(2 ** (FRAC_BITS - 1));

  logic signed [PosW-1:0]   pos [3];
  logic signed [PW-1:0]     p7_q [9];
  logic signed [MW-1:0]     m7_q [9];
  logic signed [PosW-1:0]   pos7_q [3];
  logic                     rot7_q;
  logic                     vld7_q;
  logic signed [TransW-1:0] trans_d [3];
  logic signed [TransW-1:0] trans_q [3];
  logic signed [MW-1:0]     m8_q [9];
  logic                     vld8_q;

  // half away from zero; result stays within three times the offset range
  function automatic logic signed [RW-1:0] rnd(input logic signed [AW-1:0] v);
    logic [AW-1:0]        mag;
    logic [AW:0]          r;
    logic signed [RW-1:0] res;
    mag = v[AW-1] ? unsigned'(-v) : unsigned'(v);
    r   = ({1'b0, mag} + Half) >> FRAC_BITS;
    res = signed'({1'b0, r[RW-2:0]});
    return v[AW-1] ? -res : res;
  endfunction

  assign pos[0] = side_i.pos_x;
  assign pos[1] = side_i.pos_y;
  assign pos[2] = side_i.pos_z;

  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [RW-1:0] r;
    for (int i = 0; i < 3; i++) begin
      acc = AW'(p7_q[3*i]) + AW'(p7_q[3*i+1]) + AW'(p7_q[3*i+2]);
      r   = rnd(acc);
      if (!rot7_q)                     trans_d[i] = TransW'(pos7_q[i]);
      else if (r > RW'(TransMax))      trans_d[i] = TransW'(TransMax);
      else if (r < RW'(TransMin))      trans_d[i] = TransW'(TransMin);
      else                             trans_d[i] = TransW'(r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld7_q <= 1'b0;
      vld8_q <= 1'b0;
    end else begin
      vld7_q <= side_i.vld;
      vld8_q <= vld7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p7_q[3*i+j] <= PW'(m_i[3*i+j]) * PW'(pos[j]);
      end
    end
    m7_q    <= m_i;
    pos7_q  <= pos;
    rot7_q  <= side_i.rot;
    m8_q    <= m7_q;
    trans_q <= trans_d;
  end

  assign m_o     = m8_q;
  assign trans_o = trans_q;
  assign valid_o = vld8_q;

endmodule

FILE: rtl/euler_pose_to_homogeneous.sv
// Top level: Z-Y-X Euler pose to homogeneous transform (rotation + translation).
// Instantiates epth_angle, epth_rot and epth_xlate. Depends on epth_pkg.
//
//   channel   direction  handshake              payload
//   command   in         start_i, busy_o        roll/pitch/yaw_deg_i, pos_x/y/z_i,
//                                               rotate_first_i
//   result    out        valid_o (1-cycle)      m00_o..m22_o, trans_x/y/z_o
//
// One pose per clock; each result is registered, in order, by the
// eight register stages (reduce, lookup, multiply, round, multiply, sum/clamp,
// multiply, sum/saturate). busy_o stays low: nothing in the pipeline stalls.
// Reset clears the valid bits and the offset side path (not in epth_xlate); the sine table is constant logic.
module euler_pose_to_homogeneous #(
  parameter int FRAC_BITS = epth_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [epth_pkg::AngW-1:0]   roll_deg_i,
  input  logic signed [epth_pkg::AngW-1:0]   pitch_deg_i,
  input  logic signed [epth_pkg::AngW-1:0]   yaw_deg_i,
  input  logic signed [epth_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [epth_pkg::PosW-1:0]   pos_y_i,
  input  logic signed [epth_pkg::PosW-1:0]   pos_z_i,
  input  logic                               rotate_first_i,
  output logic                               valid_o,
  output logic signed [FRAC_BITS+1:0]        m00_o,
  output logic signed [FRAC_BITS+1:0]        m01_o,
  output logic signed [FRAC_BITS+1:0]        m02_o,
  output logic signed [FRAC_BITS+1:0]        m10_o,
  output logic signed [FRAC_BITS+1:0]        m11_o,
  output logic signed [FRAC_BITS+1:0]        m12_o,
  output logic signed [FRAC_BITS+1:0]        m20_o,
  output logic signed [FRAC_BITS+1:0]        m21_o,
  output logic signed [FRAC_BITS+1:0]        m22_o,
  output logic signed [epth_pkg::TransW-1:0] trans_x_o,
  output logic signed [epth_pkg::TransW-1:0] trans_y_o,
  output logic signed [epth_pkg::TransW-1:0] trans_z_o
);
  import epth_pkg::*;

  logic signed [AngW-1:0]      ang [3];
  side_t                       side_in;
  side_t                       side_ang;
  side_t                       side_rot;
  logic signed [FRAC_BITS+1:0] sin_v [3];
  logic signed [FRAC_BITS+1:0] cos_v [3];
  logic signed [FRAC_BITS+1:0] m_rot [9];
  logic signed [FRAC_BITS+1:0] m_out [9];
  logic signed [TransW-1:0]    trans [3];

  assign busy_o = 1'b0;

  assign ang[0] = roll_deg_i;
  assign ang[1] = pitch_deg_i;
  assign ang[2] = yaw_deg_i;

  assign side_in.vld   = start_i && !busy_o;
  assign side_in.pos_x = pos_x_i;
  assign side_in.pos_y = pos_y_i;
  assign side_in.pos_z = pos_z_i;
  assign side_in.rot   = rotate_first_i;

  epth_angle #(.FRAC_BITS(FRAC_BITS)) u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ang_i  (ang),
    .side_i (side_in),
    .sin_o  (sin_v),
    .cos_o  (cos_v),
    .side_o (side_ang)
  );

  epth_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sin_i  (sin_v),
    .cos_i  (cos_v),
    .side_i (side_ang),
    .m_o    (m_rot),
    .side_o (side_rot)
  );

  epth_xlate #(.FRAC_BITS(FRAC_BITS)) u_xlate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .m_i     (m_rot),
    .side_i  (side_rot),
    .m_o     (m_out),
    .trans_o (trans),
    .valid_o (valid_o)
  );

  assign m00_o     = m_out[0];
  assign m01_o     = m_out[1];
  assign m02_o     = m_out[2];
  assign m10_o     = m_out[3];
  assign m11_o     = m_out[4];
  assign m12_o     = m_out[5];
  assign m20_o     = m_out[6];
  assign m21_o     = m_out[7];
  assign m22_o     = m_out[8];
  assign trans_x_o = trans[0];
  assign trans_y_o = trans[1];
  assign trans_z_o = trans[2];

endmodule

FILE: dv/euler_pose_to_homogeneous_tb.sv
// Self-checking testbench for euler_pose_to_homogeneous: directed table, then random poses,
// each checked against typed values or an in-bench Z-Y-X rotation/translation predictor.
// Depends on epth_pkg (port widths) and the RTL top level.
module euler_pose_to_homogeneous_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC         = 16;
  localparam int MW           = FRAC + 2;
  localparam int XW           = epth_pkg::TransW;
  localparam int N_RANDOM     = 1880;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS  = 10;

  localparam longint unsigned PI_Q31   = 64'd6746518852;
  localparam longint unsigned HALF_Q31 = 64'd1 << 30;
  localparam longint          ONE_FX   = longint'(1) << FRAC;
  localparam longint          HALF_FX  = longint'(1) << (FRAC - 1);
  localparam longint          XL_MAX   = 1048575;
  localparam longint          XL_MIN   = -1048576;

  typedef struct packed {
    logic signed [epth_pkg::AngW-1:0] roll;
    logic signed [epth_pkg::AngW-1:0] pitch;
    logic signed [epth_pkg::AngW-1:0] yaw;
    logic signed [epth_pkg::PosW-1:0] px;
    logic signed [epth_pkg::PosW-1:0] py;
    logic signed [epth_pkg::PosW-1:0] pz;
    logic                             rot_first;
  } pose_cmd_t;

  // rot[0] is m00 (row-major), xl[0] is trans_x
  typedef struct packed {
    logic [8:0][MW-1:0] rot;
    logic [2:0][XW-1:0] xl;
  } pose_mat_t;

  typedef struct packed {
    logic                   typed;
    logic [8:0][MW-1:0]     exp_rot;
    logic signed [XW-1:0]   exp_x;
    logic signed [XW-1:0]   exp_y;
    logic signed [XW-1:0]   exp_z;
    pose_cmd_t              cmd;
  } dir_row_t;

  // concatenation order is m22 .. m00
  localparam logic [8:0][MW-1:0] ROT_IDENT = {
    18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536};
  localparam logic [8:0][MW-1:0] ROT_HALF_Z = {
    18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536};
  localparam logic [8:0][MW-1:0] NO_ROT = '0;
  localparam logic [3*XW-1:0]    NO_XL  = '0;

  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // zero angles: identity, offset passes through in both modes
    {1'b1, ROT_IDENT, 21'sd0, 21'sd0, 21'sd0,
     {10'sd0, 10'sd0, 10'sd0, 20'sd0, 20'sd0, 20'sd0, 1'b0}},
    {1'b1, ROT_IDENT, 21'sd524287, 21'sd524287, 21'sd524287,
     {10'sd0, 10'sd0, 10'sd0, 20'sd524287, 20'sd524287, 20'sd524287, 1'b1}},
    {1'b1, ROT_IDENT, -21'sd524288, -21'sd524288, -21'sd524288,
     {10'sd0, 10'sd0, 10'sd0, -20'sd524288, -20'sd524288, -20'sd524288, 1'b1}},
    // full turns reduce to zero
    {1'b1, ROT_IDENT, 21'sd524287, -21'sd524288, 21'sd1,
     {10'sd360, -10'sd360, 10'sd0, 20'sd524287, -20'sd524288, 20'sd1, 1'b0}},
    {1'b1, ROT_IDENT, -21'sd1, 21'sd65536, -21'sd65536,
     {-10'sd360, 10'sd360, -10'sd360, -20'sd1, 20'sd65536, -20'sd65536, 1'b1}},
    // half turn about z flips x and y; the offset only in rotate-first mode
    {1'b1, ROT_HALF_Z, 21'sd524288, -21'sd524287, 21'sd12345,
     {10'sd0, 10'sd0, 10'sd180, -20'sd524288, 20'sd524287, 20'sd12345, 1'b1}},
    {1'b1, ROT_HALF_Z, 21'sd100, -21'sd200, 21'sd300,
     {10'sd0, 10'sd0, -10'sd180, 20'sd100, -20'sd200, 20'sd300, 1'b0}},
    // quarter turns, gimbal lock, quadrant edges, out-of-range angles
    {1'b0, NO_ROT, NO_XL, {10'sd90, 10'sd0, 10'sd0, 20'sd70000, -20'sd3000, 20'sd5, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd0, 10'sd90, 10'sd0, 20'sd70000, -20'sd3000, 20'sd5, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd0, 10'sd0, 10'sd90, 20'sd70000, -20'sd3000, 20'sd5, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd270, -10'sd90, 10'sd45, 20'sd1, 20'sd2, 20'sd3, 1'b1}},
    {1'b0, NO_ROT, NO_XL,
     {10'sd511, -10'sd512, 10'sd511, 20'sd524287, -20'sd524288, 20'sd524287, 1'b1}},
    {1'b0, NO_ROT, NO_XL,
     {-10'sd512, 10'sd511, -10'sd1, -20'sd524288, 20'sd524287, -20'sd524288, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd45, 10'sd30, 10'sd60, 20'sd65536, 20'sd65536, 20'sd65536, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd1, 10'sd89, 10'sd91, -20'sd77777, 20'sd4242, 20'sd99, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd179, 10'sd181, 10'sd269, 20'sd123456, 20'sd0, -20'sd7, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd271, 10'sd359, -10'sd359, 20'sd32768, -20'sd32768, 20'sd1, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd359, -10'sd1, 10'sd1, 20'sd11, 20'sd22, 20'sd33, 1'b0}},
    {1'b0, NO_ROT, NO_XL,
     {10'sd135, 10'sd225, 10'sd315, 20'sd524287, 20'sd524287, 20'sd524287, 1'b1}},
    {1'b0, NO_ROT, NO_XL,
     {10'sd30, -10'sd45, 10'sd120, -20'sd524288, -20'sd524288, -20'sd524288, 1'b1}},
    {1'b0, NO_ROT, NO_XL,
     {10'sd90, 10'sd90, 10'sd90, 20'sd524287, -20'sd524288, 20'sd524287, 1'b1}},
    {1'b0, NO_ROT, NO_XL,
     {-10'sd90, -10'sd90, -10'sd90, -20'sd524288, 20'sd524287, -20'sd524288, 1'b1}},
    {1'b0, NO_ROT, NO_XL, {10'sd17, 10'sd263, 10'sd344, -20'sd1, 20'sd1, -20'sd1, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic signed [epth_pkg::AngW-1:0] roll_deg_i;
  logic signed [epth_pkg::AngW-1:0] pitch_deg_i;
  logic signed [epth_pkg::AngW-1:0] yaw_deg_i;
  logic signed [epth_pkg::PosW-1:0] pos_x_i;
  logic signed [epth_pkg::PosW-1:0] pos_y_i;
  logic signed [epth_pkg::PosW-1:0] pos_z_i;
  logic                             rotate_first_i;
  logic                             valid_o;
  logic signed [MW-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic signed [XW-1:0] trans_x_o, trans_y_o, trans_z_o;

  pose_mat_t expect_q [$];
  longint    sin_lut [0:90];
  int        fail_cnt   = 0;
  int        cycle_cnt  = 0;
  int        burst_left = 0;

  euler_pose_to_homogeneous dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .roll_deg_i     (roll_deg_i),
    .pitch_deg_i    (pitch_deg_i),
    .yaw_deg_i      (yaw_deg_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .rotate_first_i (rotate_first_i),
    .valid_o        (valid_o),
    .m00_o          (m00_o),
    .m01_o          (m01_o),
    .m02_o          (m02_o),
    .m10_o          (m10_o),
    .m11_o          (m11_o),
    .m12_o          (m12_o),
    .m20_o          (m20_o),
    .m21_o          (m21_o),
    .m22_o          (m22_o),
    .trans_x_o      (trans_x_o),
    .trans_y_o      (trans_y_o),
    .trans_z_o      (trans_z_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // sin(deg), deg in 0..90: Taylor series in unsigned Q31, each step rounded half up
  function automatic longint sine_first_quadrant(input int deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned den;
    longint          acc;
    ang    = (longint'(unsigned'(deg)) * PI_Q31 + 64'd90) / 64'd180;
    ang_sq = (ang * ang + HALF_Q31) >> 31;
    term   = ang;
    acc    = longint'(ang);
    for (int k = 1; k <= 9; k++) begin
      den  = longint'(2 * k) * longint'(2 * k + 1);
      term = (((term * ang_sq + HALF_Q31) >> 31) + den / 2) / den;
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 31)) acc = longint'(1) << 31;
    return longint'((longint'(acc) + (longint'(1) << (30 - FRAC))) >>> (31 - FRAC));
  endfunction

  function automatic longint sin_deg(input int a);
    case (a / 90)
      0:       return sin_lut[a % 90];
      1:       return sin_lut[90 - a % 90];
      2:       return -sin_lut[a % 90];
      default: return -sin_lut[90 - a % 90];
    endcase
  endfunction

  function automatic int wrap_deg(input logic signed [epth_pkg::AngW-1:0] a);
    int v;
    v = a;
    v = v % 360;
    if (v < 0) v += 360;
    return v;
  endfunction

  // round to FRAC bits, half away from zero
  function automatic longint round_frac(input longint v);
    if (v >= 0) return (v + HALF_FX) >>> FRAC;
    return -((-v + HALF_FX) >>> FRAC);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return round_frac(a * b);
  endfunction

  function automatic pose_mat_t predict_pose(input pose_cmd_t c);
    longint    sx, cx, sy, cy, sz, cz, czsy, szsy, acc;
    longint    m [9];
    longint    p [3];
    longint    t;
    int        ar, ap, ay;
    pose_mat_t res;
    ar   = wrap_deg(c.roll);
    ap   = wrap_deg(c.pitch);
    ay   = wrap_deg(c.yaw);
    sx   = sin_deg(ar);
    cx   = sin_deg((ar + 90) % 360);
    sy   = sin_deg(ap);
    cy   = sin_deg((ap + 90) % 360);
    sz   = sin_deg(ay);
    cz   = sin_deg((ay + 90) % 360);
    czsy = fx_mul(cz, sy);
    szsy = fx_mul(sz, sy);
    p[0] = c.px;
    p[1] = c.py;
    p[2] = c.pz;
    // R = Rz(yaw) * Ry(pitch) * Rx(roll)
    m[0] = fx_mul(cz, cy);
    m[1] = fx_mul(czsy, sx) - fx_mul(sz, cx);
    m[2] = fx_mul(czsy, cx) + fx_mul(sz, sx);
    m[3] = fx_mul(sz, cy);
    m[4] = fx_mul(szsy, sx) + fx_mul(cz, cx);
    m[5] = fx_mul(szsy, cx) - fx_mul(cz, sx);
    m[6] = -sy;
    m[7] = fx_mul(cy, sx);
    m[8] = fx_mul(cy, cx);
    for (int i = 0; i < 9; i++) begin
      if (m[i] > ONE_FX)  m[i] = ONE_FX;
      if (m[i] < -ONE_FX) m[i] = -ONE_FX;
      res.rot[i] = m[i][MW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      if (c.rot_first) begin
        acc = m[3*i] * p[0] + m[3*i+1] * p[1] + m[3*i+2] * p[2];
        t   = round_frac(acc);
        if (t > XL_MAX) t = XL_MAX;
        if (t < XL_MIN) t = XL_MIN;
      end else begin
        t = p[i];
      end
      res.xl[i] = t[XW-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : result_check
    pose_mat_t got;
    pose_mat_t want;
    if (rst_ni === 1'b1 && valid_o !== 1'b0) begin
      got.rot = {m22_o, m21_o, m20_o, m12_o, m11_o, m10_o, m02_o, m01_o, m00_o};
      got.xl  = {trans_z_o, trans_y_o, trans_x_o};
      if (valid_o !== 1'b1) begin
        note_fail("valid_o is unknown");
      end else if (expect_q.size() == 0) begin
        note_fail("result transfer with no pose pending");
      end else begin
        want = expect_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.rot[i] !== want.rot[i])
            note_fail($sformatf("m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                                $signed(want.rot[i]), $signed(got.rot[i])));
        for (int i = 0; i < 3; i++)
          if (got.xl[i] !== want.xl[i])
            note_fail($sformatf("trans_%s: expected %0d, got %0d",
                                i == 0 ? "x" : (i == 1 ? "y" : "z"),
                                $signed(want.xl[i]), $signed(got.xl[i])));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [epth_pkg::AngW-1:0] rand_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 10'(int'($urandom_range(0, 720)) - 360);
    if (r < 92) return 10'($urandom);
    return 10'(90 * int'($urandom_range(0, 8)) - 360);
  endfunction

  function automatic logic signed [epth_pkg::PosW-1:0] rand_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 20'($urandom);
    if (r < 88) return 20'sd524287;
    if (r < 96) return -20'sd524288;
    return 20'(int'($urandom_range(0, 2)) - 1);
  endfunction

  // mostly back-to-back or short gaps, a few long ones, and gap-free bursts
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 2) begin
      burst_left = $urandom_range(30, 90);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // command lines carry junk while start is low
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start_i        <= 1'b0;
      roll_deg_i     <= 10'($urandom);
      pitch_deg_i    <= 10'($urandom);
      yaw_deg_i      <= 10'($urandom);
      pos_x_i        <= 20'($urandom);
      pos_y_i        <= 20'($urandom);
      pos_z_i        <= 20'($urandom);
      rotate_first_i <= 1'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic send_pose(input pose_cmd_t c, input pose_mat_t want);
    start_i        <= 1'b1;
    roll_deg_i     <= c.roll;
    pitch_deg_i    <= c.pitch;
    yaw_deg_i      <= c.yaw;
    pos_x_i        <= c.px;
    pos_y_i        <= c.py;
    pos_z_i        <= c.pz;
    rotate_first_i <= c.rot_first;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expect_q = {expect_q, want};
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expect_q.size() != 0);
  endtask

  initial begin : stimulus
    pose_cmd_t cmd;
    pose_mat_t want;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    roll_deg_i     = '0;
    pitch_deg_i    = '0;
    yaw_deg_i      = '0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    rotate_first_i = 1'b0;
    for (int r = 0; r <= 90; r++) sin_lut[r] = sine_first_quadrant(r);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < N_DIR; k++) begin
      pause_sender(pick_gap());
      if (DIR_ROWS[k].typed) begin
        want.rot = DIR_ROWS[k].exp_rot;
        want.xl  = {DIR_ROWS[k].exp_z, DIR_ROWS[k].exp_y, DIR_ROWS[k].exp_x};
      end else begin
        want = predict_pose(DIR_ROWS[k].cmd);
      end
      send_pose(DIR_ROWS[k].cmd, want);
    end
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      // sender holds off now and then until the pipeline is empty
      if (n > 0 && n % 400 == 0) drain_results();
      pause_sender(pick_gap());
      cmd.roll      = rand_angle();
      cmd.pitch     = rand_angle();
      cmd.yaw       = rand_angle();
      cmd.px        = rand_pos();
      cmd.py        = rand_pos();
      cmd.pz        = rand_pos();
      cmd.rot_first = 1'($urandom);
      send_pose(cmd, predict_pose(cmd));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expect_q.size() != 0) note_fail("poses left without a result");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/epth_pkg.sv
rtl/epth_angle.sv
rtl/epth_rot.sv
rtl/epth_xlate.sv
rtl/euler_pose_to_homogeneous.sv
dv/euler_pose_to_homogeneous_tb.sv
